FILE: sv/ppts_pkg.sv
// Types, constants and saturation helpers of the periodic Poisson solver.
// No dependencies; all other files of the block import this package.
`timescale 1ns / 1ps

package ppts_pkg;

	// Q16.16 word and wide accumulator used for exact sums
	localparam int Q_W   = 32;
	localparam int ACC_W = 40;
	localparam int PT_IDX_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int SWEEP_W = 8;

	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN  = 32'sh8000_0000;
	localparam q_t Q_HALF = 32'sd32768;
	localparam q_t Q_ONE  = 32'sd65536;
	localparam q_t Q_TWO  = 32'sd131072;
	localparam acc_t ACC_TWO = 40'sd131072;
	localparam acc_t ACC_ONE_LSB = 40'sd1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEPS  = 1'd1;

	localparam logic [31:0]        SPACING_RST = 32'd65536;
	localparam logic [SWEEP_W-1:0] SWEEPS_RST  = 8'd50;

	// divider request and response
	typedef struct packed {
		logic start;
		q_t   num;
		q_t   den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		q_t   quo;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE,
		ST_F0, ST_F0_DIV, ST_F0_SET,
		ST_FL_P, ST_FL_T, ST_FL_H, ST_FL_R, ST_FL_W,
		ST_C_S, ST_C_T, ST_C_BO, ST_C_BG, ST_C_BO2, ST_C_BG2,
		ST_B_RD, ST_B_M1, ST_B_M2, ST_B_M3, ST_B_M4, ST_B_M5,
		ST_P_SRC, ST_P_DIV, ST_P_SET,
		ST_Q_RD, ST_Q_M, ST_Q_W, ST_Q_Z,
		ST_J_CHK, ST_J_SRC, ST_J_ADD, ST_J_Z0, ST_J_Z1, ST_J_Z2,
		ST_E_RD, ST_E_LD, ST_E_OUT,
		ST_SRC_RD, ST_SRC_MUL, ST_MUL_W, ST_DIV_W
	} state_t;

	function automatic acc_t ext(input q_t x);
		return {{(ACC_W-Q_W){x[Q_W-1]}}, x};
	endfunction

	// clamp a wide sum to the signed 32-bit range
	function automatic q_t sat_acc(input acc_t x);
		logic all_same;
		all_same = (&x[ACC_W-1:Q_W-1]) | ~(|x[ACC_W-1:Q_W-1]);
		if (all_same) begin
			return x[Q_W-1:0];
		end
		return x[ACC_W-1] ? Q_MIN : Q_MAX;
	endfunction

	// saturated negation; equals a product with the -1 stencil weight
	function automatic q_t qneg(input q_t x);
		return sat_acc(-ext(x));
	endfunction

endpackage

FILE: sv/ppts_if.sv
// Stream interfaces of the solver: density samples in, potentials out.
// Depends on ppts_pkg for the payload types.
`timescale 1ns / 1ps

interface ppts_sample_if;
	import ppts_pkg::*;
	logic valid;
	logic ready;
	q_t   density;
	logic last_sample;
	modport source (output valid, density, last_sample, input ready);
	modport sink (input valid, density, last_sample, output ready);
endinterface

interface ppts_result_if;
	import ppts_pkg::*;
	logic                valid;
	logic                ready;
	q_t                  potential;
	logic [PT_IDX_W-1:0] point_index;
	logic                last_point;
	modport source (output valid, potential, point_index, last_point, input ready);
	modport sink (input valid, potential, point_index, last_point, output ready);
endinterface

FILE: sv/ppts_div.sv
// Iterative Q16.16 divider: (num * 2^16) / den, truncated, saturated.
// Restoring division, one quotient bit per cycle. Depends on ppts_pkg.
`timescale 1ns / 1ps

module ppts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ppts_pkg::div_req_t req,
	output ppts_pkg::div_rsp_t rsp
);
	import ppts_pkg::*;

	localparam int DVD_W = Q_W + 16;
	localparam int CW    = $clog2(DVD_W);

	logic          busy_q, fin_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [Q_W-1:0]   rem_q, dsr_q;
	logic [DVD_W-1:0] dvd_q;
	logic          neg_q;
	q_t            quo_q;

	logic [Q_W:0]     rem_sh;
	logic             ge;
	logic [Q_W-1:0]   rem_n;
	logic [DVD_W-1:0] dvd_n;
	logic [Q_W-1:0]   abs_n, abs_d;
	q_t               quo_fin;

	// operand magnitudes
	assign abs_n = req.num[Q_W-1] ? Q_W'(~req.num + 1'b1) : req.num;
	assign abs_d = req.den[Q_W-1] ? Q_W'(~req.den + 1'b1) : req.den;

	// one restoring step
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_n  = ge ? Q_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[Q_W-1:0];
	assign dvd_n  = {dvd_q[DVD_W-2:0], ge};

	// sign and saturation of the finished magnitude
	always_comb begin
		if (neg_q) begin
			quo_fin = (dvd_q > DVD_W'(33'h1_0000_0000 >> 1)) ? Q_MIN : Q_W'(~dvd_q[Q_W-1:0] + 1'b1);
		end else begin
			quo_fin = (dvd_q > DVD_W'(32'h7FFF_FFFF)) ? Q_MAX : dvd_q[Q_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= {abs_n, 16'b0};
			dsr_q <= abs_d;
			neg_q <= req.num[Q_W-1] ^ req.den[Q_W-1];
			if (req.den == '0) begin
				quo_q <= req.num[Q_W-1] ? Q_MIN : Q_MAX;
			end
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
		end else if (fin_q) begin
			quo_q <= quo_fin;
		end
	end

	assign rsp.busy = busy_q | fin_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: sv/periodic_poisson_tridiagonal_solver_unit.sv
// Periodic 1-D Poisson solver: collects GRID_CELLS+1 density samples (the last one flagged),
// solves the cyclic -1/2/-1 system by elimination and back substitution in Q16.16, refines
// with jacobi_sweeps Jacobi sweeps and streams GRID_CELLS+1 potentials in index order. The
// solve runs on one shared multiplier and one shared 48-step divider under a sequencer:
// 3*GRID_CELLS-2 divisions set the direct solve, followed by back substitution, potential
// substitution and the Jacobi sweeps; the potentials then stream out as the sink takes them.
// No sample is taken from the flagged one until the last potential has been delivered.
// Depends on ppts_pkg, ppts_if (ppts_sample_if, ppts_result_if) and ppts_div.
`timescale 1ns / 1ps

module periodic_poisson_tridiagonal_solver_unit #(
	parameter int GRID_CELLS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ppts_sample_if.sink                       sample_ch,
	ppts_result_if.source                     result_ch,
	input  logic                              cfg_we,
	input  logic [ppts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import ppts_pkg::*;

	localparam int AW = $clog2(GRID_CELLS + 1);
	localparam int FW = $clog2(GRID_CELLS);
	localparam logic [AW-1:0] N_A = AW'(GRID_CELLS);

	// configuration
	logic [31:0]        spacing_q;
	logic [SWEEP_W-1:0] sweeps_q;

	// sequencer
	state_t state_q, state_d, ret_q, ret_d;
	logic [AW-1:0] idx_q, idx_d, src_k_q, src_k_d, load_cnt_q, load_cnt_d;
	logic [SWEEP_W-1:0] sweep_q, sweep_d;

	// working registers
	q_t fr_p_q, fr_p_d, wr_p_q, wr_p_d, fh_p_q, fh_p_d, p_q, p_d, s_q, s_d, den_q, den_d;
	q_t bo_l_q, bo_l_d, bg_l_q, bg_l_d, bo_n_q, bo_n_d, bg_n_q, bg_n_d, phi_q, phi_d;
	q_t w_prev_q, w_prev_d, w_cur_q, w_cur_d, p1old_q, p1old_d, pot0_q, pot0_d;
	q_t pot1_q, pot1_d;
	acc_t t_q, t_d;

	// shared multiplier
	logic signed [Q_W:0]       ma_q, ma_d, mb_q, mb_d;
	logic                      mul_ld;
	logic signed [2*Q_W+1:0]   prod_q, prod_rnd, prod_sh;
	q_t                        mq;

	// shared divider
	div_req_t div_req;
	div_rsp_t div_rsp;

	// output register
	logic                ov_q, ov_d, olast_q, olast_d;
	q_t                  opot_q, opot_d;
	logic [PT_IDX_W-1:0] oidx_q, oidx_d;

	// memories
	q_t dens_mem [GRID_CELLS+1];
	q_t pot_mem  [GRID_CELLS+1];
	q_t fr_mem   [GRID_CELLS];
	q_t wr_mem   [GRID_CELLS];
	q_t fh_mem   [GRID_CELLS];
	q_t bo_mem   [GRID_CELLS];
	q_t bg_mem   [GRID_CELLS];
	q_t dens_rd_q, pot_rd_q, fr_rd_q, wr_rd_q, fh_rd_q, bo_rd_q, bg_rd_q;

	logic          dens_we, pot_we, fr_we, wr_we, fh_we, bo_we, bg_we;
	logic [AW-1:0] dens_wa, pot_wa, pot_ra;
	logic [FW-1:0] bo_wa, bg_wa;
	q_t            dens_wd, pot_wd, fr_wd, wr_wd, fh_wd, bo_wd, bg_wd;

	logic sample_acc, result_acc;

	assign sample_acc = sample_ch.valid & sample_ch.ready;
	assign result_acc = result_ch.valid & result_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);

	assign result_ch.valid       = ov_q;
	assign result_ch.potential   = opot_q;
	assign result_ch.point_index = oidx_q;
	assign result_ch.last_point  = olast_q;

	ppts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// multiplier result: round half up, drop 16 fraction bits, saturate
	assign prod_rnd = prod_q + (2*Q_W+2)'(32768);
	assign prod_sh  = prod_rnd >>> 16;
	always_comb begin
		if ((&prod_sh[2*Q_W+1:Q_W-1]) | ~(|prod_sh[2*Q_W+1:Q_W-1])) begin
			mq = prod_sh[Q_W-1:0];
		end else begin
			mq = prod_sh[2*Q_W+1] ? Q_MIN : Q_MAX;
		end
	end

	// pot read address: emit reads index i, everything else reads i+1
	always_comb begin
		if (state_q inside {ST_E_RD, ST_E_LD, ST_E_OUT}) begin
			pot_ra = idx_q;
		end else begin
			pot_ra = idx_q + AW'(1);
		end
	end

	// sequencer next state and datapath controls
	always_comb begin
		acc_t sum;
		q_t   v;

		state_d = state_q;  ret_d = ret_q;
		idx_d = idx_q;  src_k_d = src_k_q;  load_cnt_d = load_cnt_q;  sweep_d = sweep_q;
		fr_p_d = fr_p_q;  wr_p_d = wr_p_q;  fh_p_d = fh_p_q;  p_d = p_q;  s_d = s_q;
		den_d = den_q;  bo_l_d = bo_l_q;  bg_l_d = bg_l_q;  bo_n_d = bo_n_q;  bg_n_d = bg_n_q;
		phi_d = phi_q;  w_prev_d = w_prev_q;  w_cur_d = w_cur_q;  p1old_d = p1old_q;
		pot0_d = pot0_q;  pot1_d = pot1_q;  t_d = t_q;
		ma_d = ma_q;  mb_d = mb_q;  mul_ld = 1'b0;
		div_req = '0;
		ov_d = ov_q;  opot_d = opot_q;  oidx_d = oidx_q;  olast_d = olast_q;
		dens_we = 1'b0;  dens_wa = load_cnt_q;  dens_wd = sample_ch.density;
		pot_we = 1'b0;  pot_wa = idx_q;  pot_wd = '0;
		fr_we = 1'b0;  fr_wd = '0;  wr_we = 1'b0;  wr_wd = '0;  fh_we = 1'b0;  fh_wd = '0;
		bo_we = 1'b0;  bo_wa = idx_q[FW-1:0];  bo_wd = '0;
		bg_we = 1'b0;  bg_wa = idx_q[FW-1:0];  bg_wd = '0;
		sum = '0;
		v = '0;

		case (state_q)
			// sample loading
			ST_IDLE: begin
				if (sample_acc) begin
					if (sample_ch.last_sample) begin
						load_cnt_d = '0;
						if (load_cnt_q >= N_A) begin
							dens_we = 1'b1;
							dens_wa = N_A;
							idx_d   = '0;
							state_d = ST_F0;
						end
					end else begin
						dens_we = 1'b1;
						if (load_cnt_q < N_A) begin
							load_cnt_d = load_cnt_q + AW'(1);
						end
					end
				end
			end
			// first elimination row
			ST_F0: begin
				fr_we = 1'b1;  fr_wd = Q_HALF;  fr_p_d = Q_HALF;
				wr_we = 1'b1;  wr_wd = Q_HALF;  wr_p_d = Q_HALF;
				src_k_d = AW'(1);  ret_d = ST_F0_DIV;  state_d = ST_SRC_RD;
			end
			ST_F0_DIV: begin
				div_req.start = 1'b1;  div_req.num = mq;  div_req.den = Q_TWO;
				ret_d = ST_F0_SET;  state_d = ST_DIV_W;
			end
			ST_F0_SET: begin
				fh_we = 1'b1;  fh_wd = div_rsp.quo;  fh_p_d = div_rsp.quo;
				idx_d = AW'(1);  state_d = ST_FL_P;
			end
			// forward elimination loop
			ST_FL_P: begin
				p_d = sat_acc(ext(qneg(fr_p_q)) + ACC_TWO);
				src_k_d = idx_q + AW'(1);  ret_d = ST_FL_T;  state_d = ST_SRC_RD;
			end
			ST_FL_T: begin
				div_req.start = 1'b1;
				div_req.num = sat_acc(ext(mq) - ext(qneg(fh_p_q)));
				div_req.den = p_q;
				ret_d = ST_FL_H;  state_d = ST_DIV_W;
			end
			ST_FL_H: begin
				fh_we = 1'b1;  fh_wd = div_rsp.quo;  fh_p_d = div_rsp.quo;
				div_req.start = 1'b1;  div_req.num = Q_ONE;  div_req.den = p_q;
				ret_d = ST_FL_R;  state_d = ST_DIV_W;
			end
			ST_FL_R: begin
				fr_we = 1'b1;  fr_wd = div_rsp.quo;  fr_p_d = div_rsp.quo;
				div_req.start = 1'b1;
				div_req.num = sat_acc(-ext(qneg(wr_p_q)));
				div_req.den = p_q;
				ret_d = ST_FL_W;  state_d = ST_DIV_W;
			end
			ST_FL_W: begin
				wr_we = 1'b1;  wr_wd = div_rsp.quo;  wr_p_d = div_rsp.quo;
				if (idx_q == AW'(GRID_CELLS - 2)) begin
					state_d = ST_C_S;
				end else begin
					idx_d = idx_q + AW'(1);
					state_d = ST_FL_P;
				end
			end
			// close the cyclic system
			ST_C_S: begin
				v = sat_acc(ext(fr_p_q) + ext(wr_p_q));
				s_d = v;
				den_d = sat_acc(ext(qneg(v)) + ACC_TWO);
				src_k_d = N_A;  ret_d = ST_C_T;  state_d = ST_SRC_RD;
			end
			ST_C_T: begin
				div_req.start = 1'b1;
				div_req.num = sat_acc(ext(mq) - ext(qneg(fh_p_q)));
				div_req.den = den_q;
				ret_d = ST_C_BO;  state_d = ST_DIV_W;
			end
			ST_C_BO: begin
				bo_we = 1'b1;  bo_wa = FW'(GRID_CELLS - 1);  bo_wd = div_rsp.quo;
				bo_l_d = div_rsp.quo;
				div_req.start = 1'b1;  div_req.num = Q_ONE;  div_req.den = den_q;
				ret_d = ST_C_BG;  state_d = ST_DIV_W;
			end
			ST_C_BG: begin
				bg_we = 1'b1;  bg_wa = FW'(GRID_CELLS - 1);  bg_wd = div_rsp.quo;
				bg_l_d = div_rsp.quo;
				mul_ld = 1'b1;  ma_d = {s_q[Q_W-1], s_q};  mb_d = {bo_l_q[Q_W-1], bo_l_q};
				ret_d = ST_C_BO2;  state_d = ST_MUL_W;
			end
			ST_C_BO2: begin
				v = sat_acc(ext(fh_p_q) + ext(mq));
				bo_we = 1'b1;  bo_wa = FW'(GRID_CELLS - 2);  bo_wd = v;  bo_n_d = v;
				mul_ld = 1'b1;  ma_d = {s_q[Q_W-1], s_q};  mb_d = {bg_l_q[Q_W-1], bg_l_q};
				ret_d = ST_C_BG2;  state_d = ST_MUL_W;
			end
			ST_C_BG2: begin
				bg_we = 1'b1;  bg_wa = FW'(GRID_CELLS - 2);  bg_wd = mq;  bg_n_d = mq;
				idx_d = AW'(GRID_CELLS - 3);  state_d = ST_B_RD;
			end
			// back substitution loop, downward
			ST_B_RD: begin
				state_d = ST_B_M1;
			end
			ST_B_M1: begin
				t_d = ext(fh_rd_q);
				mul_ld = 1'b1;  ma_d = {fr_rd_q[Q_W-1], fr_rd_q};  mb_d = {bo_n_q[Q_W-1], bo_n_q};
				ret_d = ST_B_M2;  state_d = ST_MUL_W;
			end
			ST_B_M2: begin
				t_d = t_q + ext(mq);
				mul_ld = 1'b1;  ma_d = {wr_rd_q[Q_W-1], wr_rd_q};  mb_d = {bo_l_q[Q_W-1], bo_l_q};
				ret_d = ST_B_M3;  state_d = ST_MUL_W;
			end
			ST_B_M3: begin
				v = sat_acc(t_q + ext(mq));
				bo_we = 1'b1;  bo_wd = v;  bo_n_d = v;
				mul_ld = 1'b1;  ma_d = {fr_rd_q[Q_W-1], fr_rd_q};  mb_d = {bg_n_q[Q_W-1], bg_n_q};
				ret_d = ST_B_M4;  state_d = ST_MUL_W;
			end
			ST_B_M4: begin
				t_d = ext(mq);
				mul_ld = 1'b1;  ma_d = {wr_rd_q[Q_W-1], wr_rd_q};  mb_d = {bg_l_q[Q_W-1], bg_l_q};
				ret_d = ST_B_M5;  state_d = ST_MUL_W;
			end
			ST_B_M5: begin
				v = sat_acc(t_q + ext(mq));
				bg_we = 1'b1;  bg_wd = v;  bg_n_d = v;
				if (idx_q == AW'(1)) begin
					state_d = ST_P_SRC;
				end else begin
					idx_d = idx_q - AW'(1);
					state_d = ST_B_RD;
				end
			end
			// periodic unknown
			ST_P_SRC: begin
				src_k_d = AW'(1);  ret_d = ST_P_DIV;  state_d = ST_SRC_RD;
			end
			ST_P_DIV: begin
				div_req.start = 1'b1;
				div_req.num = sat_acc(ext(mq) - ext(qneg(bo_n_q)) - ext(qneg(bo_l_q)));
				div_req.den = sat_acc(ACC_TWO + ext(qneg(bg_n_q)) + ext(qneg(bg_l_q)));
				ret_d = ST_P_SET;  state_d = ST_DIV_W;
			end
			ST_P_SET: begin
				phi_d = div_rsp.quo;  pot1_d = div_rsp.quo;
				pot_we = 1'b1;  pot_wa = AW'(1);  pot_wd = div_rsp.quo;
				idx_d = AW'(1);  state_d = ST_Q_RD;
			end
			// potentials from offsets and gains
			ST_Q_RD: begin
				state_d = ST_Q_M;
			end
			ST_Q_M: begin
				mul_ld = 1'b1;  ma_d = {bg_rd_q[Q_W-1], bg_rd_q};  mb_d = {phi_q[Q_W-1], phi_q};
				ret_d = ST_Q_W;  state_d = ST_MUL_W;
			end
			ST_Q_W: begin
				v = sat_acc(ext(bo_rd_q) + ext(mq));
				pot_we = 1'b1;  pot_wa = idx_q + AW'(1);  pot_wd = v;
				if (idx_q == AW'(GRID_CELLS - 1)) begin
					pot0_d = v;
					state_d = ST_Q_Z;
				end else begin
					idx_d = idx_q + AW'(1);
					state_d = ST_Q_RD;
				end
			end
			ST_Q_Z: begin
				pot_we = 1'b1;  pot_wa = '0;  pot_wd = pot0_q;
				sweep_d = '0;  state_d = ST_J_CHK;
			end
			// Jacobi sweeps, in place with a sliding window of old values
			ST_J_CHK: begin
				if (sweep_q == sweeps_q) begin
					idx_d = '0;
					state_d = ST_E_RD;
				end else begin
					idx_d = AW'(1);
					w_prev_d = pot0_q;  w_cur_d = pot1_q;  p1old_d = pot1_q;
					state_d = ST_J_SRC;
				end
			end
			ST_J_SRC: begin
				src_k_d = idx_q;  ret_d = ST_J_ADD;  state_d = ST_SRC_RD;
			end
			ST_J_ADD: begin
				sum = ext(pot_rd_q) + ext(w_prev_q) + ext(mq) + ACC_ONE_LSB;
				v = sat_acc(sum >>> 1);
				pot_we = 1'b1;  pot_wd = v;
				if (idx_q == AW'(1)) begin
					pot1_d = v;
				end
				w_prev_d = w_cur_q;  w_cur_d = pot_rd_q;
				if (idx_q == AW'(GRID_CELLS - 1)) begin
					state_d = ST_J_Z0;
				end else begin
					idx_d = idx_q + AW'(1);
					state_d = ST_J_SRC;
				end
			end
			ST_J_Z0: begin
				src_k_d = '0;  ret_d = ST_J_Z1;  state_d = ST_SRC_RD;
			end
			ST_J_Z1: begin
				sum = ext(w_prev_q) + ext(p1old_q) + ext(mq) + ACC_ONE_LSB;
				v = sat_acc(sum >>> 1);
				pot_we = 1'b1;  pot_wa = '0;  pot_wd = v;  pot0_d = v;
				state_d = ST_J_Z2;
			end
			ST_J_Z2: begin
				pot_we = 1'b1;  pot_wa = N_A;  pot_wd = pot0_q;
				sweep_d = sweep_q + SWEEP_W'(1);
				state_d = ST_J_CHK;
			end
			// result streaming
			ST_E_RD: begin
				state_d = ST_E_LD;
			end
			ST_E_LD: begin
				ov_d = 1'b1;  opot_d = pot_rd_q;  oidx_d = PT_IDX_W'(idx_q);
				olast_d = (idx_q == N_A);
				state_d = ST_E_OUT;
			end
			ST_E_OUT: begin
				if (result_acc) begin
					ov_d = 1'b0;
					if (olast_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + AW'(1);
						state_d = ST_E_RD;
					end
				end
			end
			// shared subroutines: source term, multiply, divide
			ST_SRC_RD: begin
				state_d = ST_SRC_MUL;
			end
			ST_SRC_MUL: begin
				mul_ld = 1'b1;  ma_d = {dens_rd_q[Q_W-1], dens_rd_q};  mb_d = {1'b0, spacing_q};
				state_d = ST_MUL_W;
			end
			ST_MUL_W: begin
				state_d = ret_q;
			end
			ST_DIV_W: begin
				if (div_rsp.done) begin
					state_d = ret_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			idx_q      <= '0;
			src_k_q    <= '0;
			load_cnt_q <= '0;
			sweep_q    <= '0;
			ov_q       <= 1'b0;
			spacing_q  <= SPACING_RST;
			sweeps_q   <= SWEEPS_RST;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			idx_q      <= idx_d;
			src_k_q    <= src_k_d;
			load_cnt_q <= load_cnt_d;
			sweep_q    <= sweep_d;
			ov_q       <= ov_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_SPACING: spacing_q <= cfg_data;
					REG_SWEEPS:  sweeps_q  <= cfg_data[SWEEP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fr_p_q <= fr_p_d;  wr_p_q <= wr_p_d;  fh_p_q <= fh_p_d;  p_q <= p_d;
		s_q <= s_d;  den_q <= den_d;  bo_l_q <= bo_l_d;  bg_l_q <= bg_l_d;
		bo_n_q <= bo_n_d;  bg_n_q <= bg_n_d;  phi_q <= phi_d;
		w_prev_q <= w_prev_d;  w_cur_q <= w_cur_d;  p1old_q <= p1old_d;
		pot0_q <= pot0_d;  pot1_q <= pot1_d;  t_q <= t_d;
		opot_q <= opot_d;  oidx_q <= oidx_d;  olast_q <= olast_d;
		if (mul_ld) begin
			ma_q <= ma_d;
			mb_q <= mb_d;
		end
		prod_q <= ma_q * mb_q;
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (dens_we) begin
			dens_mem[dens_wa] <= dens_wd;
		end
		dens_rd_q <= dens_mem[src_k_q];
	end

	always_ff @(posedge clk) begin
		if (pot_we) begin
			pot_mem[pot_wa] <= pot_wd;
		end
		pot_rd_q <= pot_mem[pot_ra];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[idx_q[FW-1:0]] <= fr_wd;
		end
		fr_rd_q <= fr_mem[idx_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_we) begin
			wr_mem[idx_q[FW-1:0]] <= wr_wd;
		end
		wr_rd_q <= wr_mem[idx_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fh_we) begin
			fh_mem[idx_q[FW-1:0]] <= fh_wd;
		end
		fh_rd_q <= fh_mem[idx_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bo_we) begin
			bo_mem[bo_wa] <= bo_wd;
		end
		bo_rd_q <= bo_mem[idx_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bg_we) begin
			bg_mem[bg_wa] <= bg_wd;
		end
		bg_rd_q <= bg_mem[idx_q[FW-1:0]];
	end

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.ready |-> !result_ch.valid)
		else $error("sample accepted while a result is pending");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= N_A)
		else $error("load count beyond grid size");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(result_acc && result_ch.last_point) |=> (state_q == ST_IDLE && load_cnt_q == '0))
		else $error("block not idle after the final potential");

endmodule

FILE: sim/periodic_poisson_tridiagonal_solver_unit_test.sv
// Self-checking bench for the periodic Poisson solver: density frames in, potentials out.
// Holds its own Q16.16 solver to predict every potential; needs ppts_pkg, ppts_if and the RTL.
`timescale 1ns / 1ps

module periodic_poisson_tridiagonal_solver_unit_test;
	import ppts_pkg::*;

	localparam int CELLS = 32;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD = 400;

	typedef struct {
		q_t   density;
		logic last;
	} sample_t;

	typedef struct {
		q_t                  potential;
		logic [PT_IDX_W-1:0] index;
		logic                last;
	} potential_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	ppts_sample_if smp ();
	ppts_result_if res ();

	periodic_poisson_tridiagonal_solver_unit #(.GRID_CELLS(CELLS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(smp),
		.result_ch(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sample_t    pending_samples[$];
	potential_t expected_potentials[$];
	int errors = 0;
	int idle_cycles = 0;
	bit in_took = 0;
	bit out_took = 0;
	bit hold_req = 0;
	bit calm = 0;
	int sgap = 0;
	int rgap = 0;
	int hold_cnt = 0;

	// solver state of the predictor
	longint spacing;
	longint sweeps;
	int     load_cnt;
	longint rho [0:CELLS];
	longint phi [0:CELLS];
	longint scr [0:CELLS];
	longint fr [0:CELLS-1];
	longint wr [0:CELLS-1];
	longint fh [0:CELLS-1];
	longint bo [0:CELLS-1];
	longint bg [0:CELLS-1];

	// clock: 8 ns period
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint sat32(input longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return sat32((a * b + 64'sd32768) >>> 16);
	endfunction

	function automatic longint qdiv(input longint n0, input longint d0);
		longint n;
		longint d;
		n = sat32(n0);
		d = sat32(d0);
		if (d == 0) begin
			return (n >= 0) ? 64'sd2147483647 : -64'sd2147483648;
		end
		return sat32((n * 64'sd65536) / d);
	endfunction

	function automatic longint source_term(input int i);
		return qmul(rho[i], spacing);
	endfunction

	// cyclic elimination, periodic closure, then Jacobi refinement
	task automatic solve_potentials();
		longint p;
		longint s;
		longint den;
		longint phi1;
		longint sum;
		longint a;
		longint b;
		a = -64'sd65536;
		b = 64'sd131072;
		p = b;
		fr[0] = qdiv(-a, p);
		wr[0] = qdiv(-a, p);
		fh[0] = qdiv(source_term(1), p);
		for (int i = 1; i < CELLS - 1; i++) begin
			p = sat32(qmul(a, fr[i-1]) + b);
			fh[i] = qdiv(sat32(source_term(i + 1) - qmul(a, fh[i-1])), p);
			fr[i] = qdiv(-a, p);
			wr[i] = qdiv(sat32(-qmul(a, wr[i-1])), p);
		end
		s = sat32(fr[CELLS-2] + wr[CELLS-2]);
		den = sat32(qmul(a, s) + b);
		bo[CELLS-1] = qdiv(sat32(source_term(CELLS) - qmul(a, fh[CELLS-2])), den);
		bg[CELLS-1] = qdiv(-a, den);
		bo[CELLS-2] = sat32(fh[CELLS-2] + qmul(s, bo[CELLS-1]));
		bg[CELLS-2] = qmul(s, bg[CELLS-1]);
		for (int i = CELLS - 3; i > 0; i--) begin
			bo[i] = sat32(fh[i] + qmul(fr[i], bo[i+1]) + qmul(wr[i], bo[CELLS-1]));
			bg[i] = sat32(qmul(fr[i], bg[i+1]) + qmul(wr[i], bg[CELLS-1]));
		end
		phi1 = qdiv(sat32(source_term(1) - qmul(a, bo[1]) - qmul(a, bo[CELLS-1])),
			sat32(b + qmul(a, bg[1]) + qmul(a, bg[CELLS-1])));
		phi[1] = phi1;
		for (int i = 1; i < CELLS; i++) begin
			phi[i+1] = sat32(bo[i] + qmul(bg[i], phi1));
		end
		phi[0] = phi[CELLS];
		for (int j = 0; j < sweeps; j++) begin
			for (int i = 1; i < CELLS; i++) begin
				sum = phi[i+1] + phi[i-1] + source_term(i);
				scr[i] = sat32((sum + 1) >>> 1);
			end
			sum = phi[CELLS-1] + phi[1] + source_term(0);
			scr[0] = sat32((sum + 1) >>> 1);
			scr[CELLS] = scr[0];
			phi = scr;
		end
	endtask

	// one accepted sample: load, drop an early-flagged frame, or solve
	task automatic take_sample(input q_t d, input logic last);
		potential_t r;
		if (load_cnt > CELLS) begin
			load_cnt = CELLS;
		end
		if (last) begin
			if (load_cnt < CELLS) begin
				load_cnt = 0;
				return;
			end
			rho[CELLS] = longint'(d);
			load_cnt = 0;
			solve_potentials();
			for (int i = 0; i <= CELLS; i++) begin
				r.potential = q_t'(phi[i]);
				r.index = PT_IDX_W'(i);
				r.last = (i == CELLS);
				expected_potentials.push_back(r);
			end
		end else begin
			rho[load_cnt] = longint'(d);
			if (load_cnt < CELLS) begin
				load_cnt++;
			end
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic q_t rand_density();
		if ($urandom_range(0, 1) == 0) begin
			return q_t'($urandom);
		end
		return q_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	task automatic push_sample(input q_t d, input logic last);
		sample_t s;
		s.density = d;
		s.last = last;
		pending_samples.push_back(s);
	endtask

	// a full frame: GRID_CELLS unflagged samples and the flagged one
	task automatic push_frame();
		for (int i = 0; i < CELLS; i++) begin
			push_sample(rand_density(), 1'b0);
		end
		push_sample(rand_density(), 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SPACING) begin
			spacing = longint'({32'b0, value});
		end else begin
			sweeps = longint'(value[SWEEP_W-1:0]);
		end
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || smp.valid || expected_potentials.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample driver, changes at the falling edge
	always @(negedge clk) begin
		sample_t it;
		logic nv;
		if (arst_n) begin
			if (in_took) begin
				in_took = 0;
				nv = 1'b0;
				sgap = pick_gap();
			end else begin
				nv = smp.valid;
			end
			if (!nv) begin
				if (sgap > 0) begin
					sgap--;
				end else if (pending_samples.size() > 0) begin
					it = pending_samples.pop_front();
					smp.density <= it.density;
					smp.last_sample <= it.last;
					nv = 1'b1;
				end
			end
			smp.valid <= nv;
		end
	end

	// potential receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		logic r;
		if (arst_n) begin
			if (out_took) begin
				out_took = 0;
				rgap = pick_gap();
			end
			if (hold_req && res.valid) begin
				hold_req = 0;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				r = 1'b0;
			end else if (rgap > 0) begin
				rgap--;
				r = 1'b0;
			end else begin
				r = 1'b1;
			end
			res.ready <= r;
		end
	end

	// monitor: predict on each sample transaction, check each potential transaction
	always @(posedge clk) begin
		potential_t e;
		if (arst_n) begin
			idle_cycles++;
			if (smp.valid && smp.ready) begin
				in_took = 1;
				idle_cycles = 0;
				take_sample(smp.density, smp.last_sample);
			end
			if (res.valid && res.ready) begin
				out_took = 1;
				idle_cycles = 0;
				if (expected_potentials.size() == 0) begin
					errors++;
					$display("%0t: unexpected potential %h index %0d last %b", $time,
						res.potential, res.point_index, res.last_point);
				end else begin
					e = expected_potentials.pop_front();
					if (res.potential !== e.potential || res.point_index !== e.index
							|| res.last_point !== e.last) begin
						errors++;
						$display("%0t: expected potential %h index %0d last %b, got %h %0d %b",
							$time, e.potential, e.index, e.last,
							res.potential, res.point_index, res.last_point);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("periodic_poisson_tridiagonal_solver_unit_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPACING;
		cfg_data = 32'd0;
		smp.valid = 1'b0;
		smp.density = '0;
		smp.last_sample = 1'b0;
		res.ready = 1'b0;
		spacing = 64'sd65536;
		sweeps = 64'sd50;
		load_cnt = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: early flag, then a frame of extremes with two extra samples
		push_sample(Q_MAX, 1'b1);
		push_sample(Q_MAX, 1'b0);
		push_sample(Q_MIN, 1'b0);
		push_sample('0, 1'b0);
		push_sample(32'sd1, 1'b0);
		push_sample(-32'sd1, 1'b0);
		push_sample(Q_ONE, 1'b0);
		for (int i = 6; i < CELLS + 2; i++) begin
			push_sample(rand_density(), 1'b0);
		end
		push_sample(Q_MIN, 1'b1);
		wait_idle();

		// largest spacing and sweep count
		write_reg(REG_SPACING, 32'hFFFF_FFFF);
		write_reg(REG_SWEEPS, 32'd255);
		for (int i = 0; i < CELLS; i++) begin
			push_sample((i % 2) ? Q_MAX : Q_MIN, 1'b0);
		end
		push_sample(Q_MAX, 1'b1);
		wait_idle();

		// random spacing, no sweeps, a broken frame and a long receiver hold-off
		write_reg(REG_SPACING, $urandom_range(0, 32'h0004_0000));
		write_reg(REG_SWEEPS, 32'd0);
		hold_req = 1;
		push_sample(rand_density(), 1'b0);
		push_sample(rand_density(), 1'b1);
		push_frame();
		wait_idle();

		if (errors == 0) begin
			$display("periodic_poisson_tridiagonal_solver_unit_test: PASS");
		end else begin
			$display("periodic_poisson_tridiagonal_solver_unit_test: FAIL");
		end
		$finish;
	end

endmodule
